/* rtl/lbcd_pkg.sv */
// Shared types and codes of the block cache directory.
`default_nettype none
package lbcd_pkg;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 17;
    localparam int BLK_W    = 16;
    localparam int FSIZE_W  = 32;
    localparam int OFS_W    = 32;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 9;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FILL   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DROP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COMMIT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FAIL   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DROP   = 3'd5;
endpackage
`default_nettype wire

/* rtl/lbcd_tag_ram.sv */
// Tag memory: one entry per slot holding handle, block, length and last use.
`default_nettype none
module lbcd_tag_ram import lbcd_pkg::*; #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/lru_block_cache_directory.sv */
// Block cache directory: tag memory with sequential scan for lookup and victim choice.
// Lookup: one pass over the slots in use for hit search, then,
// once all slots are in use, a second pass for the invalid or oldest slot.
// Fill completes when it is taken; drop is one read-modify-write pass over the slots.
// One item in work at a time; the result sits in an output register.
// Reset is synchronous; a clearing pass over the tag memory follows it.
`default_nettype none
module lru_block_cache_directory import lbcd_pkg::*; #(
    parameter int BLOCK_BYTES = 65536,
    parameter int SLOT_COUNT  = 512,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: func[1:0], file_handle[17:2], block_number[33:18], file_size[65:34],
    // fill_ok[66], zero fill to 72 bits
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: status[2:0], slot[11:3], fill_offset[43:12], valid_length[60:44], zero fill
    output logic      [63:0] m_axis_tdata
);
    localparam int AW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW     = $clog2(SLOT_COUNT + 1);
    localparam int SHIFT  = $clog2(BLOCK_BYTES);
    localparam int FLW    = SHIFT + 1;
    localparam int DW     = HANDLE_BITS + BLK_W + FLW + TIME_W;
    localparam logic [FLW-1:0] BLK_LEN = FLW'(BLOCK_BYTES);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HSCAN = 8'b0000_0100,
        S_VSCAN = 8'b0000_1000,
        S_MISS  = 8'b0001_0000,
        S_DSCAN = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_HITWR = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [BLK_W-1:0]       blk;
        logic [FLW-1:0]         len;
        logic [TIME_W-1:0]      last;
    } t_entry;

    t_state r_state, n_state;
    logic [CW-1:0] r_used;
    logic [TIME_W-1:0] r_clock;
    logic [AW-1:0] r_pslot;
    logic [HANDLE_BITS-1:0] r_phandle;
    logic [BLK_W-1:0] r_pblock;
    logic [FLW-1:0] r_plen;
    logic [HANDLE_BITS-1:0] r_h;
    logic [BLK_W-1:0] r_blk;
    logic [FSIZE_W-1:0] r_fsize;
    // Scan: read address counter and a delayed copy for the returning data.
    logic [CW-1:0] r_ra, r_da;
    logic r_dv;
    logic [AW-1:0] r_best;
    logic [TIME_W-1:0] r_best_t;
    logic r_found;
    t_entry r_hit;
    logic [AW-1:0] r_hit_slot;
    logic r_ovalid;
    logic [STATUS_W-1:0] r_st;
    logic [SLOT_W-1:0] r_oslot;
    logic [OFS_W-1:0] r_ofs;
    logic [LEN_W-1:0] r_olen;

    logic we;
    logic [AW-1:0] waddr;
    t_entry wdata, rdata;
    logic [DW-1:0] rbits;
    logic [AW-1:0] raddr;

    // Addresses past the last slot read slot zero.
    assign raddr = (r_ra >= CW'(SLOT_COUNT)) ? '0 : r_ra[AW-1:0];

    lbcd_tag_ram #(.DEPTH(SLOT_COUNT), .ADDR_W(AW), .DATA_W(DW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rbits));
    assign rdata = t_entry'(rbits);

    // Input fields.
    logic [FUNC_W-1:0] in_func;
    logic [HANDLE_BITS-1:0] in_h;
    assign in_func = s_axis_tdata[1:0];
    assign in_h    = HANDLE_BITS'(s_axis_tdata[17:2] & 16'((33'd1 << HANDLE_BITS) - 1));

    // Block start and clipped length of the current lookup.
    logic [47:0] start;
    logic [48:0] rest;
    logic [FLW-1:0] clip;
    assign start = 48'(r_blk) * 48'(BLOCK_BYTES);
    assign rest  = {17'd0, r_fsize} - {1'b0, start};
    always_comb begin
        if (start[47:32] != '0 || rest[48] || rest == '0) clip = '0;
        else if (rest > 49'(BLOCK_BYTES)) clip = BLK_LEN;
        else clip = FLW'(rest);
    end
    logic [47:0] pstart;
    assign pstart = 48'(r_pblock) * 48'(BLOCK_BYTES);

    logic scan_last;
    assign scan_last = r_dv && (r_da == r_used - CW'(1));
    logic match;
    assign match = rdata.len != '0 && rdata.handle == r_h && rdata.blk == r_blk;

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, r_olen, r_ofs, r_oslot, r_st};

    // Memory write port.
    always_comb begin
        we = 1'b0;
        waddr = r_da[AW-1:0];
        wdata = rdata;
        unique case (r_state)
            S_CLEAR: begin
                we = 1'b1; waddr = r_ra[AW-1:0]; wdata = '0;
            end
            S_HITWR: begin
                we = 1'b1; waddr = r_hit_slot; wdata = r_hit; wdata.last = r_clock;
            end
            S_MISS: begin
                we = 1'b1; waddr = r_best; wdata = rdata; wdata.len = '0;
            end
            S_DSCAN: begin
                we = r_dv && rdata.handle == r_h; wdata.len = '0;
            end
            S_IDLE: begin
                we = s_axis_tvalid && s_axis_tready && in_func == FUNC_FILL
                     && r_plen != '0 && s_axis_tdata[66];
                waddr = r_pslot;
                wdata = '{handle: r_phandle, blk: r_pblock, len: r_plen, last: r_clock};
            end
            default: ;
        endcase
    end

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_used <= '0; r_clock <= '0; r_pslot <= '0; r_phandle <= '0;
            r_pblock <= '0; r_plen <= '0; r_ra <= '0; r_dv <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            r_state <= n_state;
            r_da <= r_ra;
            unique case (r_state)
                S_CLEAR: begin
                    r_ra <= r_ra + CW'(1);
                    if (r_ra == CW'(SLOT_COUNT - 1)) r_ra <= '0;
                end
                S_IDLE: begin
                    r_ra <= '0; r_dv <= 1'b0; r_found <= 1'b0;
                    r_best <= '0; r_best_t <= '1;
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_h <= in_h; r_blk <= s_axis_tdata[33:18];
                        r_fsize <= s_axis_tdata[65:34];
                        unique case (in_func)
                            FUNC_LOOKUP: begin
                                r_clock <= r_clock + TIME_W'(1); r_plen <= '0;
                                r_dv <= r_used != '0; r_ra <= CW'(1);
                            end
                            FUNC_FILL: begin
                                r_ovalid <= 1'b1; r_st <= ST_FAIL;
                                r_oslot <= SLOT_W'(r_pslot);
                                r_ofs <= (r_plen == '0) ? '0 : pstart[31:0];
                                r_olen <= LEN_W'(r_plen);
                                if (r_plen != '0 && s_axis_tdata[66]) r_st <= ST_COMMIT;
                                r_plen <= '0;
                            end
                            FUNC_DROP: begin
                                r_dv <= r_used != '0; r_ra <= CW'(1);
                                if (r_phandle == in_h) r_plen <= '0;
                                if (r_used == '0) begin
                                    r_ovalid <= 1'b1; r_st <= ST_DROP;
                                    r_oslot <= '0; r_ofs <= '0; r_olen <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_HSCAN, S_VSCAN, S_DSCAN: begin
                    r_ra <= r_ra + CW'(1);
                    if (r_ra == r_used) r_dv <= 1'b0;
                    if (r_state == S_HSCAN && r_dv && match && !r_found) begin
                        r_found <= 1'b1; r_hit <= rdata; r_hit_slot <= r_da[AW-1:0];
                    end
                    if (r_state == S_VSCAN && r_dv && !r_found) begin
                        if (rdata.len == '0) begin
                            r_found <= 1'b1; r_best <= r_da[AW-1:0];
                        end else if (rdata.last < r_best_t || r_da == '0) begin
                            r_best <= r_da[AW-1:0]; r_best_t <= rdata.last;
                        end
                    end
                    if (r_state == S_DSCAN && scan_last) begin
                        r_ovalid <= 1'b1; r_st <= ST_DROP;
                        r_oslot <= '0; r_ofs <= '0; r_olen <= '0;
                    end
                    // The victim pass starts over at slot zero, which is read at this edge.
                    if (r_state == S_HSCAN && (scan_last || !r_dv) && !(r_dv && match)
                        && !r_found && r_used == CW'(SLOT_COUNT)) begin
                        r_ra <= CW'(1); r_dv <= 1'b1; r_da <= '0;
                    end
                    if (r_state == S_HSCAN && (r_dv && match || r_found || scan_last || !r_dv)
                        && r_used != CW'(SLOT_COUNT) && !(r_dv && match) && !r_found) begin
                        r_best <= AW'(r_used); r_used <= r_used + CW'(1);
                    end
                end
                S_HITWR: begin
                    r_ovalid <= 1'b1; r_st <= ST_HIT; r_oslot <= SLOT_W'(r_hit_slot);
                    r_ofs <= start[31:0]; r_olen <= LEN_W'(r_hit.len);
                end
                S_MISS: begin
                    r_ovalid <= 1'b1; r_oslot <= SLOT_W'(r_best); r_ofs <= start[31:0];
                    r_olen <= LEN_W'(clip);
                    r_st <= (clip == '0) ? ST_BEYOND : ST_MISS;
                    if (clip != '0) begin
                        r_pslot <= r_best; r_phandle <= r_h; r_pblock <= r_blk; r_plen <= clip;
                    end
                end
                // Point the read port at slot zero before the next item can be taken.
                S_OUT: r_ra <= '0;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_ra == CW'(SLOT_COUNT - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    if (in_func == FUNC_LOOKUP) n_state = S_HSCAN;
                    else if (in_func == FUNC_DROP && r_used != '0) n_state = S_DSCAN;
                end
            end
            S_HSCAN: begin
                if ((r_dv && match) || r_found) n_state = S_HITWR;
                else if (scan_last || !r_dv)
                    n_state = (r_used == CW'(SLOT_COUNT)) ? S_VSCAN : S_MISS;
            end
            S_VSCAN: if (!r_dv && r_da == r_used) n_state = S_MISS;
            S_DSCAN: if (scan_last) n_state = S_OUT;
            S_HITWR: n_state = S_OUT;
            S_MISS:  n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
